>>> rtl/nrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrf_pkg: shared constants of the normal-to-frame block
// Matrix entry numbering and the fixed width of the result fields.
// ----------------------------------------------------------------------------
package nrf_pkg;

	// Nine matrix entries, row-major: u, v, n.
	localparam int LANES = 9;

	localparam int LANE_UX = 0;
	localparam int LANE_UY = 1;
	localparam int LANE_UZ = 2;
	localparam int LANE_VX = 3;
	localparam int LANE_VY = 4;
	localparam int LANE_VZ = 5;
	localparam int LANE_NX = 6;
	localparam int LANE_NY = 7;
	localparam int LANE_NZ = 8;

	// Width of each matrix field on the result channel.
	localparam int RES_W = 16;

	typedef logic signed [RES_W-1:0] res_t;

endpackage
`default_nettype wire

>>> rtl/nrf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrf_in_if: normal vector input channel
// Valid/ready channel carrying one signed normal vector per transfer.
// ----------------------------------------------------------------------------
interface nrf_in_if #(
	parameter int IN_WIDTH = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] normal_x;
	logic signed [IN_WIDTH-1:0] normal_y;
	logic signed [IN_WIDTH-1:0] normal_z;

	modport source (output valid, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink (input valid, input normal_x, input normal_y, input normal_z,
		output ready);
endinterface
`default_nettype wire

>>> rtl/nrf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrf_out_if: rotation frame output channel
// Valid/ready channel carrying one 3x3 matrix and a degenerate flag per transfer.
// ----------------------------------------------------------------------------
interface nrf_out_if;
	logic                valid;
	logic                ready;
	nrf_pkg::res_t       tangent_u_x;
	nrf_pkg::res_t       tangent_u_y;
	nrf_pkg::res_t       tangent_u_z;
	nrf_pkg::res_t       bitangent_v_x;
	nrf_pkg::res_t       bitangent_v_y;
	nrf_pkg::res_t       bitangent_v_z;
	nrf_pkg::res_t       unit_n_x;
	nrf_pkg::res_t       unit_n_y;
	nrf_pkg::res_t       unit_n_z;
	logic                degenerate;

	modport source (output valid, input ready,
		output tangent_u_x, output tangent_u_y, output tangent_u_z,
		output bitangent_v_x, output bitangent_v_y, output bitangent_v_z,
		output unit_n_x, output unit_n_y, output unit_n_z, output degenerate);
	modport sink (input valid, output ready,
		input tangent_u_x, input tangent_u_y, input tangent_u_z,
		input bitangent_v_x, input bitangent_v_y, input bitangent_v_z,
		input unit_n_x, input unit_n_y, input unit_n_z, input degenerate);
endinterface
`default_nettype wire

>>> rtl/nrf_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrf_prep: operand preparation for the root cells
// Four stages: component products, frame vectors, squares and denominators,
// then the initial error term of each entry's search.
// ----------------------------------------------------------------------------
module nrf_prep #(
	parameter int IN_WIDTH      = 16,
	parameter int OUT_FRAC_BITS = 14,
	localparam int PW = 4 * IN_WIDTH,
	localparam int EW = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6
) (
	input  wire logic                       clk,
	input  wire logic [3:0]                 en,
	input  wire logic signed [IN_WIDTH-1:0] x,
	input  wire logic signed [IN_WIDTH-1:0] y,
	input  wire logic signed [IN_WIDTH-1:0] z,
	output logic [EW-1:0]                   e_s4 [nrf_pkg::LANES],
	output logic [EW-1:0]                   t_s4 [nrf_pkg::LANES],
	output logic [PW-1:0]                   p_s4 [nrf_pkg::LANES],
	output logic                            neg_s4 [nrf_pkg::LANES]
);
	localparam int SW = 2 * IN_WIDTH;
	localparam int CW = 2 * IN_WIDTH + 1;

	logic signed [SW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [IN_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic helper_y_s1;

	logic [SW-1:0] sn, vv;
	logic signed [CW-1:0] c [nrf_pkg::LANES];
	logic signed [CW-1:0] c_s2 [nrf_pkg::LANES];
	logic [SW-1:0] sn_s2, vv_s2;

	logic signed [2*CW-1:0] sq [nrf_pkg::LANES];
	logic [PW-1:0] c2_s3 [nrf_pkg::LANES];
	logic [PW-1:0] p_s3 [nrf_pkg::LANES];
	logic neg_s3 [nrf_pkg::LANES];

	// Stage 1: all pairwise products of the components.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			zz_s1 <= z * z;
			xy_s1 <= x * y;
			xz_s1 <= x * z;
			yz_s1 <= y * z;
			x_s1 <= x;
			y_s1 <= y;
			z_s1 <= z;
			helper_y_s1 <= ((x == '0) && (y == '0)) || ((y == '0) && (z == '0));
		end
	end

	// Stage 2: squared lengths and the numerators of all nine entries.
	always_comb begin
		sn = $unsigned(xx_s1) + $unsigned(yy_s1) + $unsigned(zz_s1);
		if (helper_y_s1) begin
			vv = $unsigned(xx_s1) + $unsigned(zz_s1);
			c[nrf_pkg::LANE_UX] = -CW'(xy_s1);
			c[nrf_pkg::LANE_UY] = $signed(CW'(vv));
			c[nrf_pkg::LANE_UZ] = -CW'(yz_s1);
			c[nrf_pkg::LANE_VX] = -CW'(z_s1);
			c[nrf_pkg::LANE_VY] = '0;
			c[nrf_pkg::LANE_VZ] = CW'(x_s1);
		end else begin
			vv = $unsigned(yy_s1) + $unsigned(zz_s1);
			c[nrf_pkg::LANE_UX] = $signed(CW'(vv));
			c[nrf_pkg::LANE_UY] = -CW'(xy_s1);
			c[nrf_pkg::LANE_UZ] = -CW'(xz_s1);
			c[nrf_pkg::LANE_VX] = '0;
			c[nrf_pkg::LANE_VY] = CW'(z_s1);
			c[nrf_pkg::LANE_VZ] = -CW'(y_s1);
		end
		c[nrf_pkg::LANE_NX] = CW'(x_s1);
		c[nrf_pkg::LANE_NY] = CW'(y_s1);
		c[nrf_pkg::LANE_NZ] = CW'(z_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			c_s2 <= c;
			sn_s2 <= sn;
			vv_s2 <= vv;
		end
	end

	// Stage 3: squared numerators and the product under each root.
	always_comb begin
		for (int i = 0; i < nrf_pkg::LANES; i++) begin
			sq[i] = c_s2[i] * c_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < nrf_pkg::LANES; i++) begin
				c2_s3[i] <= sq[i][PW-1:0];
				neg_s3[i] <= c_s2[i][CW-1];
			end
			for (int i = nrf_pkg::LANE_UX; i <= nrf_pkg::LANE_UZ; i++) begin
				p_s3[i] <= PW'(sn_s2) * PW'(vv_s2);
			end
			for (int i = nrf_pkg::LANE_VX; i <= nrf_pkg::LANE_VZ; i++) begin
				p_s3[i] <= PW'(vv_s2);
			end
			for (int i = nrf_pkg::LANE_NX; i <= nrf_pkg::LANE_NZ; i++) begin
				p_s3[i] <= PW'(sn_s2);
			end
		end
	end

	// Stage 4: error term for the starting point q = 0, where (2q-1)^2 = 1.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < nrf_pkg::LANES; i++) begin
				e_s4[i] <= (EW'(c2_s3[i]) << (2 * OUT_FRAC_BITS + 2)) - EW'(p_s3[i]);
				t_s4[i] <= EW'(0) - EW'(p_s3[i]);
				p_s4[i] <= p_s3[i];
				neg_s4[i] <= neg_s3[i];
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/nrf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrf_cell: one result bit of a scaled reciprocal root
// Tries to set bit BIT of q under (2q-1)^2 * P <= c^2 * 2^(2F+2), keeping the
// error term and P*(2q-1) up to date with shifts and adds only.
// ----------------------------------------------------------------------------
module nrf_cell #(
	parameter int IN_WIDTH      = 16,
	parameter int OUT_FRAC_BITS = 14,
	parameter int BIT           = 0,
	localparam int PW = 4 * IN_WIDTH,
	localparam int EW = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6,
	localparam int QW = OUT_FRAC_BITS + 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [EW-1:0] e_in,
	input  wire logic [EW-1:0] t_in,
	input  wire logic [PW-1:0] p_in,
	input  wire logic [QW-1:0] q_in,
	input  wire logic          neg_in,
	output logic [EW-1:0]      e_out,
	output logic [EW-1:0]      t_out,
	output logic [PW-1:0]      p_out,
	output logic [QW-1:0]      q_out,
	output logic               neg_out
);
	logic [EW-1:0] diff;
	logic          take;

	always_comb begin
		diff = e_in - (t_in << (BIT + 2)) - (EW'(p_in) << (2 * BIT + 2));
		// Once q has reached one exactly, no lower bit may be added.
		take = !diff[EW-1] && !((BIT < OUT_FRAC_BITS) && q_in[QW-1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_out <= take ? diff : e_in;
			t_out <= take ? (t_in + (EW'(p_in) << (BIT + 1))) : t_in;
			q_out <= q_in | (QW'(take) << BIT);
			p_out <= p_in;
			neg_out <= neg_in;
		end
	end

endmodule
`default_nettype wire

>>> rtl/normal_to_rotation_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normal_to_rotation_frame: orthonormal frame from a surface normal
// Takes one normal per cycle unless stalled; returns rotation matrix rows u, v, n.
// ----------------------------------------------------------------------------
// Usage notes.
// The normal_in channel takes one normal vector per transfer; the frame_out
// channel returns one matrix per transfer, each entry signed with
// OUT_FRAC_BITS fraction bits, rounded to nearest and saturated to 16 bits.
// Each item passes the operand preparation stages, one cell per result bit,
// and the output register. Throughput is one transfer per cycle while the
// receiver takes results, with no dependence between items.
// The entries are found by a row of root cells, one per result bit and entry,
// each deciding its bit and passing the error term to its neighbor.
// An all-zero normal yields a zero matrix with the degenerate flag set.
// Reset clears every stage valid flag, so the pipeline comes up empty.
// When the receiver stalls, each stage holds only if the stage after it is
// full and holding, so bubbles are squeezed out and normal_in keeps taking
// transfers until every stage is occupied.
// ----------------------------------------------------------------------------
module normal_to_rotation_frame #(
	parameter int IN_WIDTH      = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input wire logic  clk,
	input wire logic  arst_n,
	nrf_in_if.sink    normal_in,
	nrf_out_if.source frame_out
);
	localparam int PW    = 4 * IN_WIDTH;
	localparam int EW    = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6;
	localparam int QW    = OUT_FRAC_BITS + 1;
	localparam int NCELL = OUT_FRAC_BITS + 1;
	localparam int NS    = OUT_FRAC_BITS + 6;     // prep, cells, output register
	localparam int OUT_STAGE = NS - 1;
	localparam int SATW  = (QW + 2 > 17) ? QW + 2 : 17;

	// Stage valid flags and the enables that ripple back from the output.
	logic [NS-1:0] valid_q;
	logic [NS-1:0] en;
	logic          degen_q [OUT_STAGE];

	always_comb begin
		en[OUT_STAGE] = !valid_q[OUT_STAGE] || frame_out.ready;
		for (int i = OUT_STAGE - 1; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	assign normal_in.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= normal_in.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	// The degenerate flag rides alongside the data.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			degen_q[0] <= (normal_in.normal_x == '0) && (normal_in.normal_y == '0) &&
				(normal_in.normal_z == '0);
		end
		for (int i = 1; i < OUT_STAGE; i++) begin
			if (en[i]) begin
				degen_q[i] <= degen_q[i-1];
			end
		end
	end

	// Operand preparation occupies stages one to four.
	logic [EW-1:0] e_c   [NCELL+1][nrf_pkg::LANES];
	logic [EW-1:0] t_c   [NCELL+1][nrf_pkg::LANES];
	logic [PW-1:0] p_c   [NCELL+1][nrf_pkg::LANES];
	logic [QW-1:0] q_c   [NCELL+1][nrf_pkg::LANES];
	logic          neg_c [NCELL+1][nrf_pkg::LANES];

	nrf_prep #(
		.IN_WIDTH      (IN_WIDTH),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_prep (
		.clk    (clk),
		.en     (en[3:0]),
		.x      (normal_in.normal_x),
		.y      (normal_in.normal_y),
		.z      (normal_in.normal_z),
		.e_s4   (e_c[0]),
		.t_s4   (t_c[0]),
		.p_s4   (p_c[0]),
		.neg_s4 (neg_c[0])
	);

	always_comb begin
		for (int l = 0; l < nrf_pkg::LANES; l++) begin
			q_c[0][l] = '0;
		end
	end

	// Row of root cells: cell j settles bit OUT_FRAC_BITS - j of every entry.
	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		for (genvar l = 0; l < nrf_pkg::LANES; l++) begin : g_lane
			nrf_cell #(
				.IN_WIDTH      (IN_WIDTH),
				.OUT_FRAC_BITS (OUT_FRAC_BITS),
				.BIT           (OUT_FRAC_BITS - j)
			) u_cell (
				.clk     (clk),
				.en      (en[4+j]),
				.e_in    (e_c[j][l]),
				.t_in    (t_c[j][l]),
				.p_in    (p_c[j][l]),
				.q_in    (q_c[j][l]),
				.neg_in  (neg_c[j][l]),
				.e_out   (e_c[j+1][l]),
				.t_out   (t_c[j+1][l]),
				.p_out   (p_c[j+1][l]),
				.q_out   (q_c[j+1][l]),
				.neg_out (neg_c[j+1][l])
			);
		end
	end

	// Output register: apply the sign, saturate, and zero a degenerate frame.
	logic signed [SATW-1:0] sval [nrf_pkg::LANES];
	nrf_pkg::res_t          res  [nrf_pkg::LANES];
	nrf_pkg::res_t          res_q [nrf_pkg::LANES];
	logic                   degen_out_q;

	always_comb begin
		for (int l = 0; l < nrf_pkg::LANES; l++) begin
			sval[l] = $signed(SATW'(q_c[NCELL][l]));
			if (neg_c[NCELL][l]) begin
				sval[l] = -sval[l];
			end
			if (sval[l] > $signed(SATW'(32767))) begin
				res[l] = 16'sd32767;
			end else if (sval[l] < -$signed(SATW'(32768))) begin
				res[l] = -16'sd32768;
			end else begin
				res[l] = sval[l][nrf_pkg::RES_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[OUT_STAGE]) begin
			for (int l = 0; l < nrf_pkg::LANES; l++) begin
				res_q[l] <= degen_q[OUT_STAGE-1] ? '0 : res[l];
			end
			degen_out_q <= degen_q[OUT_STAGE-1];
		end
	end

	assign frame_out.valid         = valid_q[OUT_STAGE];
	assign frame_out.tangent_u_x   = res_q[nrf_pkg::LANE_UX];
	assign frame_out.tangent_u_y   = res_q[nrf_pkg::LANE_UY];
	assign frame_out.tangent_u_z   = res_q[nrf_pkg::LANE_UZ];
	assign frame_out.bitangent_v_x = res_q[nrf_pkg::LANE_VX];
	assign frame_out.bitangent_v_y = res_q[nrf_pkg::LANE_VY];
	assign frame_out.bitangent_v_z = res_q[nrf_pkg::LANE_VZ];
	assign frame_out.unit_n_x      = res_q[nrf_pkg::LANE_NX];
	assign frame_out.unit_n_y      = res_q[nrf_pkg::LANE_NY];
	assign frame_out.unit_n_z      = res_q[nrf_pkg::LANE_NZ];
	assign frame_out.degenerate    = degen_out_q;

endmodule
`default_nettype wire
